@@ sv/dccf_pkg.sv @@
// Shared constants and types for the two-channel centered FIR filter.
package dccf_pkg;

    localparam int TAP_SLOTS   = 63;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;

    // Width of the tap count register and of the coefficient index field
    localparam int TAP_W = 6;

    localparam int ADDR_W = (TAP_SLOTS > 1) ? $clog2(TAP_SLOTS) : 1;
    localparam int FILL_W = $clog2(TAP_SLOTS + 1);
    localparam int JW     = (ADDR_W > TAP_W) ? ADDR_W : TAP_W;
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + $clog2(TAP_SLOTS + 1);

    localparam logic [TAP_W-1:0] TAP_RESET = 6'd63;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_COEF   = 1'b1
    } t_func;

    // One classified command passed from the front end to the back end
    typedef struct packed {
        t_func                          func;
        logic signed [SAMPLE_BITS-1:0]  s0;
        logic signed [SAMPLE_BITS-1:0]  s1;
        logic                           eob;
        logic [ADDR_W-1:0]              cidx;
        logic signed [COEF_BITS-1:0]    cval;
    } t_cmd;

endpackage

@@ sv/dccf_ifs.sv @@
// Channel interfaces: input items, result items and the tap count write.
interface dccf_in_if import dccf_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic signed [SAMPLE_BITS-1:0] sample_ch0;
    logic signed [SAMPLE_BITS-1:0] sample_ch1;
    logic                          end_of_block;
    logic [TAP_W-1:0]              coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;

    modport source (output valid, func, sample_ch0, sample_ch1, end_of_block,
                    coef_index, coef_value, input ready);
    modport sink   (input valid, func, sample_ch0, sample_ch1, end_of_block,
                    coef_index, coef_value, output ready);
endinterface

interface dccf_out_if import dccf_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_ch0;
    logic signed [SAMPLE_BITS-1:0] out_ch1;
    logic                          out_last;

    modport source (output valid, out_ch0, out_ch1, out_last, input ready);
    modport sink   (input valid, out_ch0, out_ch1, out_last, output ready);
endinterface

interface dccf_cfg_if import dccf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TAP_W-1:0] tap_count;

    modport source (output valid, tap_count, input ready);
    modport sink   (input valid, tap_count, output ready);
endinterface

@@ sv/dccf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dccf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 63
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ sv/dccf_front.sv @@
// Front end: accept input items, drop out-of-range coefficient writes, queue the rest.
module dccf_front import dccf_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dccf_in_if.sink       i_in,
    output t_cmd          o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop
);
    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              xfer;
    logic              keep;
    logic              push;
    logic              pop;
    t_cmd              cmd_in;

    assign i_in.ready = (r_cnt != (QPTR_W+1)'(QUEUE_DEPTH));
    assign xfer       = i_in.valid && i_in.ready;

    // Coefficient writes beyond the tap store have no effect: drop them here
    assign keep = (t_func'(i_in.func) == FUNC_SAMPLE) || (int'(i_in.coef_index) < TAP_SLOTS);
    assign push = xfer && keep;
    assign pop  = i_cmd_pop && o_cmd_valid;

    always_comb begin
        cmd_in.func = t_func'(i_in.func);
        cmd_in.s0   = i_in.sample_ch0;
        cmd_in.s1   = i_in.sample_ch1;
        cmd_in.eob  = i_in.end_of_block;
        cmd_in.cidx = ADDR_W'(i_in.coef_index);
        cmd_in.cval = i_in.coef_value;
    end

    assign o_cmd       = r_q[r_rd];
    assign o_cmd_valid = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

@@ sv/dccf_back.sv @@
// Back end: circular delay lines, coefficient store, one MAC per channel, result register.
module dccf_back import dccf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TAP_W-1:0]  i_tap_count,
    input  t_cmd              i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    dccf_out_if.source        o_out
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEXT,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } t_state;

    localparam logic signed [ACC_W:0] RND = (ACC_W+1)'(64'sd1 <<< (COEF_BITS - 2));
    localparam logic signed [ACC_W:0] SAT_HI =
        (ACC_W+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI - 1;

    t_state                     r_state;
    logic [ADDR_W-1:0]          r_wp;
    logic [FILL_W-1:0]          r_fill;
    logic [TAP_W-1:0]           r_seen;
    logic [TAP_W-1:0]           r_flush;
    logic                       r_eob;
    logic                       r_emit;
    logic                       r_last;
    logic [TAP_SLOTS-1:0]       r_cvalid;
    logic [JW-1:0]              r_j;
    logic [JW-1:0]              r_k;
    logic [ADDR_W-1:0]          r_raddr;
    logic                       r_s1_v;
    logic                       r_s1_use;
    logic                       r_s2_v;
    logic signed [PROD_W-1:0]   r_p0;
    logic signed [PROD_W-1:0]   r_p1;
    logic signed [ACC_W-1:0]    r_acc0;
    logic signed [ACC_W-1:0]    r_acc1;
    logic                       r_out_valid;
    logic [SAMPLE_BITS-1:0]     r_o0;
    logic [SAMPLE_BITS-1:0]     r_o1;
    logic                       r_olast;

    logic [TAP_W-1:0]           taps;
    logic [TAP_W-1:0]           half;
    logic [TAP_W-1:0]           h2;
    logic [TAP_W-1:0]           seen_inc;
    logic [TAP_W-1:0]           flush_cnt;
    logic [ADDR_W-1:0]          wp_inc;
    logic [ADDR_W-1:0]          raddr_inc;
    logic [ADDR_W:0]            start_sum;
    logic [ADDR_W-1:0]          start_addr;
    logic [FILL_W-1:0]          fill_inc;
    logic                       hist_we;
    logic [2*SAMPLE_BITS-1:0]   hist_wdata;
    logic [2*SAMPLE_BITS-1:0]   hist_rd;
    logic [COEF_BITS-1:0]       coef_rd;
    logic                       coef_we;
    logic                       out_free;

    function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] v;
        logic signed [ACC_W:0] q;
        v = (ACC_W+1)'(acc) + RND;
        q = v >>> (COEF_BITS - 1);
        if (q > SAT_HI) begin
            q = SAT_HI;
        end else if (q < SAT_LO) begin
            q = SAT_LO;
        end
        return q[SAMPLE_BITS-1:0];
    endfunction

    assign taps = (int'(i_tap_count) > TAP_SLOTS) ? TAP_W'(TAP_SLOTS) : i_tap_count;
    assign half = taps >> 1;
    assign h2   = {taps[TAP_W-1:1], 1'b0};

    assign seen_inc  = (&r_seen) ? r_seen : r_seen + 1'b1;
    assign flush_cnt = i_cmd.eob ? ((seen_inc < half) ? seen_inc : half) : '0;

    assign wp_inc    = (r_wp == ADDR_W'(TAP_SLOTS - 1)) ? '0 : r_wp + 1'b1;
    assign raddr_inc = (r_raddr == ADDR_W'(TAP_SLOTS - 1)) ? '0 : r_raddr + 1'b1;
    assign fill_inc  = (r_fill == FILL_W'(TAP_SLOTS)) ? r_fill : r_fill + 1'b1;

    // Oldest tap first: history position h2 lives h2 entries behind the write pointer
    assign start_sum  = {1'b0, r_wp} + (ADDR_W+1)'(TAP_SLOTS) - (ADDR_W+1)'(h2);
    assign start_addr = (start_sum >= (ADDR_W+1)'(TAP_SLOTS)) ?
                        ADDR_W'(start_sum - (ADDR_W+1)'(TAP_SLOTS)) : ADDR_W'(start_sum);

    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        o_cmd_pop  = 1'b0;
        hist_we    = 1'b0;
        hist_wdata = '0;
        coef_we    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.func == FUNC_COEF) begin
                        coef_we = 1'b1;
                    end else begin
                        hist_we    = 1'b1;
                        hist_wdata = {i_cmd.s1, i_cmd.s0};
                    end
                end
            end
            ST_NEXT: begin
                // flush step: shift a zero pair into both lines
                if (!r_emit && (r_flush != '0)) begin
                    hist_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    dccf_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (TAP_SLOTS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (wp_inc),
        .i_wdata (hist_wdata),
        .i_raddr (r_raddr),
        .o_rdata (hist_rd)
    );

    dccf_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (TAP_SLOTS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (i_cmd.cidx),
        .i_wdata (i_cmd.cval),
        .i_raddr (ADDR_W'(r_j)),
        .o_rdata (coef_rd)
    );

    // MAC datapath: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        r_s1_use <= (r_k < JW'(r_fill)) && r_cvalid[ADDR_W'(r_j)];
        if (r_s1_use) begin
            r_p0 <= $signed(hist_rd[SAMPLE_BITS-1:0]) * $signed(coef_rd);
            r_p1 <= $signed(hist_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]) * $signed(coef_rd);
        end else begin
            r_p0 <= '0;
            r_p1 <= '0;
        end
        if (r_state == ST_NEXT && r_emit) begin
            r_acc0 <= '0;
            r_acc1 <= '0;
        end else if (r_s2_v) begin
            r_acc0 <= r_acc0 + ACC_W'(r_p0);
            r_acc1 <= r_acc1 + ACC_W'(r_p1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_seen      <= '0;
            r_flush     <= '0;
            r_eob       <= 1'b0;
            r_emit      <= 1'b0;
            r_last      <= 1'b0;
            r_cvalid    <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_raddr     <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_v <= (r_state == ST_MAC);
            r_s2_v <= r_s1_v;
            // Load a new result, or drop the held one once it is taken
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.func == FUNC_COEF) begin
                            r_cvalid[i_cmd.cidx] <= 1'b1;
                        end else begin
                            r_wp    <= wp_inc;
                            r_fill  <= fill_inc;
                            r_seen  <= seen_inc;
                            r_flush <= flush_cnt;
                            r_eob   <= i_cmd.eob;
                            r_emit  <= (seen_inc > half);
                            r_state <= ST_NEXT;
                        end
                    end
                end
                ST_NEXT: begin
                    if (r_emit) begin
                        r_emit  <= 1'b0;
                        r_last  <= r_eob && (r_flush == '0);
                        r_j     <= '0;
                        r_k     <= JW'(h2);
                        r_raddr <= start_addr;
                        r_state <= (taps == '0) ? ST_DRAIN : ST_MAC;
                    end else if (r_flush != '0) begin
                        r_wp    <= wp_inc;
                        r_fill  <= fill_inc;
                        r_flush <= r_flush - 1'b1;
                        r_emit  <= 1'b1;
                    end else begin
                        // block done: empty the delay lines by dropping the fill count
                        if (r_eob) begin
                            r_fill <= '0;
                            r_seen <= '0;
                            r_eob  <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_MAC: begin
                    r_j     <= r_j + 1'b1;
                    r_k     <= r_k - 1'b1;
                    r_raddr <= raddr_inc;
                    if (r_j == JW'(taps - 1'b1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_s1_v && !r_s2_v) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_o0        <= round_sat(r_acc0);
                        r_o1        <= round_sat(r_acc1);
                        r_olast     <= r_last;
                        r_state     <= ST_NEXT;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_ch0  = r_o0;
    assign o_out.out_ch1  = r_o1;
    assign o_out.out_last = r_olast;
endmodule

@@ sv/dual_channel_centered_fir.sv @@
// Top level of the two-channel centered FIR filter with shared coefficients.
//
// Two-channel block FIR filter with one shared set of Q1.15 coefficients. An input
// transfer with func=1 writes coefficient coef_index (indexes of 63 or more are
// dropped); func=0 carries one sample pair. With T taps in use (tap_count, reset 63)
// and half = T/2, output i of a block sums tap j times sample i-half+j, with samples
// outside the block taken as zero, and is produced once sample i+half has arrived.
// A sample with end_of_block set flushes the remaining outputs (up to half of them),
// marks the final one with out_last and empties the delay lines. Sums are rounded
// half up and saturated to 16 bits. Each output is computed by the single
// multiply-accumulate unit per channel walking the taps one per cycle through the
// single read port of the history RAM, followed by the read, multiply and
// accumulate pipeline; each flushed output is preceded by a zero shift into the
// delay lines, and a result that waits to be taken can hold up the engine.
// A four-entry command queue sits between the input side and the filter
// engine, and a result register lets the engine finish the next output while one
// waits to be taken. There is no clearing pass after reset; the delay lines are
// tracked by a fill count and the coefficient store by per-tap valid bits. Write
// tap_count only while the block is idle; the write is taken at once.
module dual_channel_centered_fir import dccf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dccf_in_if.sink     i_in,
    dccf_cfg_if.sink    i_cfg,
    dccf_out_if.source  o_out
);
    logic [TAP_W-1:0] r_tap_count;
    t_cmd             cmd;
    logic             cmd_valid;
    logic             cmd_pop;

    // Config channel never stalls
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_RESET;
        end else if (i_cfg.valid) begin
            r_tap_count <= i_cfg.tap_count;
        end
    end

    // Accept and classify input transfers, hold them in the command queue
    dccf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // Filter engine: delay lines, coefficient store, MACs and result register
    dccf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tap_count (r_tap_count),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );
endmodule

@@ sv/dccf_checker.sv @@
// Port-level checks for the two-channel centered FIR filter, bound to the top level.
module dccf_checker import dccf_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_out_ch0,
    input logic [SAMPLE_BITS-1:0] i_out_ch1,
    input logic                   i_out_last
);
    // Reset leaves no result pending
    a_out_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Reset leaves the command queue empty, so input is taken at once
    a_in_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_ch0) && $stable(i_out_ch1) && $stable(i_out_last))
        else $error("result changed while stalled");
endmodule

bind dual_channel_centered_fir dccf_checker u_dccf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_ch0   (o_out.out_ch0),
    .i_out_ch1   (o_out.out_ch1),
    .i_out_last  (o_out.out_last)
);

@@ bench/dual_channel_centered_fir_tb.sv @@
// Self-checking testbench for the two-channel centered FIR filter.
`timescale 1ns / 100ps

module dual_channel_centered_fir_tb;
    import dccf_pkg::*;

    localparam int     LIMIT_CYCLES  = 2_000_000;
    localparam int     SETTLE_CYCLES = 300;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     REPORT_MAX    = 10;
    localparam longint ROUND_BIAS    = longint'(1) <<< (COEF_BITS - 2);
    localparam longint SAT_HI        = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO        = -SAT_HI - 1;

    // One input transfer as the sender offers it
    typedef struct packed {
        t_func                         func;
        logic signed [SAMPLE_BITS-1:0] s0;
        logic signed [SAMPLE_BITS-1:0] s1;
        logic                          eob;
        logic [TAP_W-1:0]              cidx;
        logic signed [COEF_BITS-1:0]   cval;
    } t_fir_item;

    // One filtered output pair
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] ch0;
        logic signed [SAMPLE_BITS-1:0] ch1;
        logic                          is_last;
    } t_fir_result;

    logic clk = 1'b0;
    logic rst_n;

    dccf_in_if  in_ch ();
    dccf_out_if out_ch ();
    dccf_cfg_if cfg_ch ();

    dual_channel_centered_fir DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #5 clk = ~clk;

    // Items waiting for the driver, and output pairs waiting for the block
    t_fir_item   pending_items[$];
    t_fir_result expected_outputs[$];
    t_fir_item   next_item;

    // Predicted filter state: shared taps, per-channel delay lines, block fill count
    logic signed [COEF_BITS-1:0]   coef_mem [TAP_SLOTS];
    logic signed [SAMPLE_BITS-1:0] hist0    [TAP_SLOTS];
    logic signed [SAMPLE_BITS-1:0] hist1    [TAP_SLOTS];
    int                            fill_count;
    int                            taps_cfg;

    int   fault_count  = 0;
    int   cfg_writes   = 0;
    int   cycle_count  = 0;
    int   send_gap     = 0;
    int   rx_stall     = 0;
    logic in_xfer_seen = 1'b0;
    logic idle_en      = 1'b1;
    logic hold_armed   = 1'b0;
    logic rx_hold      = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Round half up at the Q1.15 point, then clamp to the sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] round_saturate(input longint acc);
        longint q;
        q = (acc + ROUND_BIAS) >>> (COEF_BITS - 1);
        if (q > SAT_HI) q = SAT_HI;
        if (q < SAT_LO) q = SAT_LO;
        return q[SAMPLE_BITS-1:0];
    endfunction

    // Push a new sample pair into both delay lines; entry 0 is the newest.
    function automatic void shift_history(input logic signed [SAMPLE_BITS-1:0] a,
                                          input logic signed [SAMPLE_BITS-1:0] b);
        for (int k = TAP_SLOTS - 1; k > 0; k--) begin
            hist0[k] = hist0[k-1];
            hist1[k] = hist1[k-1];
        end
        hist0[0] = a;
        hist1[0] = b;
    endfunction

    // Centered dot product: tap j meets the sample (2*half - j) places back.
    function automatic t_fir_result tap_sum(input logic is_last);
        t_fir_result r;
        longint      acc0;
        longint      acc1;
        int          span;
        int          k;
        acc0 = 0;
        acc1 = 0;
        span = (taps_cfg / 2) * 2;
        for (int j = 0; j < taps_cfg; j++) begin
            k = span - j;
            if (k >= 0 && k < TAP_SLOTS) begin
                acc0 += longint'(hist0[k]) * longint'(coef_mem[j]);
                acc1 += longint'(hist1[k]) * longint'(coef_mem[j]);
            end
        end
        r.ch0     = round_saturate(acc0);
        r.ch1     = round_saturate(acc1);
        r.is_last = is_last;
        return r;
    endfunction

    // Advance the predicted filter by one accepted input and queue its outputs.
    function automatic void predict_filter(input t_fir_item it);
        int half;
        int flush_n;
        if (it.func == FUNC_COEF) begin
            // Drop writes to a tap position that does not exist
            if (it.cidx < TAP_SLOTS) coef_mem[it.cidx] = it.cval;
            return;
        end
        half = taps_cfg / 2;
        shift_history(it.s0, it.s1);
        if (fill_count < 63) fill_count++;
        flush_n = 0;
        if (it.eob) flush_n = (fill_count < half) ? fill_count : half;
        // The output due now is the last one only when nothing is left to flush
        if (fill_count > half)
            expected_outputs.push_back(tap_sum(it.eob && flush_n == 0));
        if (it.eob) begin
            for (int i = 0; i < flush_n; i++) begin
                shift_history('0, '0);
                expected_outputs.push_back(tap_sum(i == flush_n - 1));
            end
            for (int k = 0; k < TAP_SLOTS; k++) begin
                hist0[k] = '0;
                hist1[k] = '0;
            end
            fill_count = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample every handshake at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        in_xfer_seen <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n) begin
            // Check results first: an output never depends on an input taken this edge
            if (out_ch.valid && out_ch.ready) begin
                if (expected_outputs.size() == 0) begin
                    if (fault_count < REPORT_MAX)
                        $display("cycle %0d: unexpected output ch0=%0d ch1=%0d last=%0b",
                                 cycle_count, out_ch.out_ch0, out_ch.out_ch1,
                                 out_ch.out_last);
                    fault_count++;
                end else begin
                    t_fir_result want;
                    want = expected_outputs.pop_front();
                    if (out_ch.out_ch0 !== want.ch0 || out_ch.out_ch1 !== want.ch1 ||
                        out_ch.out_last !== want.is_last) begin
                        if (fault_count < REPORT_MAX)
                            $display(
                                "cycle %0d: expected %0d/%0d last %0b, got %0d/%0d last %0b",
                                cycle_count, want.ch0, want.ch1, want.is_last,
                                out_ch.out_ch0, out_ch.out_ch1, out_ch.out_last);
                        fault_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                t_fir_item got;
                got.func = t_func'(in_ch.func);
                got.s0   = in_ch.sample_ch0;
                got.s1   = in_ch.sample_ch1;
                got.eob  = in_ch.end_of_block;
                got.cidx = in_ch.coef_index;
                got.cval = in_ch.coef_value;
                predict_filter(got);
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                taps_cfg = int'(cfg_ch.tap_count);
                cfg_writes++;
            end
        end
    end

    // Watchdog: end the run with a failure once the cycle limit is reached
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer queued items at the falling edge, with random gaps
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            // Load a new item only once the current one has been transferred
            if (!in_ch.valid || in_xfer_seen) begin
                if (send_gap > 0) begin
                    send_gap    <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    next_item           = pending_items.pop_front();
                    in_ch.func         <= next_item.func;
                    in_ch.sample_ch0   <= next_item.s0;
                    in_ch.sample_ch1   <= next_item.s1;
                    in_ch.end_of_block <= next_item.eob;
                    in_ch.coef_index   <= next_item.cidx;
                    in_ch.coef_value   <= next_item.cval;
                    in_ch.valid        <= 1'b1;
                    // Leave a burst of idle cycles after this transfer now and then
                    if (idle_en && $urandom_range(0, 2) == 0)
                        send_gap <= $urandom_range(1, 4);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: take results, stalling in short random bursts or a long hold
    always @(negedge clk) begin
        if (rst_n) begin
            if (rx_hold) begin
                out_ch.ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall     <= rx_stall - 1;
                out_ch.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                rx_stall     <= $urandom_range(0, 3);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Long hold on the result side while the sender keeps offering items,
    // so the command queue and result register fill and the input stalls
    initial begin
        wait (hold_armed);
        repeat (20) @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Small taps half the time so sums stay in range; otherwise full scale or extremes
    function automatic logic signed [COEF_BITS-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0:       return COEF_BITS'($urandom);
            1:       return 16'sh8000;
            2:       return 16'sh7FFF;
            default: return COEF_BITS'($urandom_range(0, 6000) - 3000);
        endcase
    endfunction

    function automatic void push_sample(input logic signed [SAMPLE_BITS-1:0] a,
                                        input logic signed [SAMPLE_BITS-1:0] b,
                                        input logic eob);
        t_fir_item it;
        it.func = FUNC_SAMPLE;
        it.s0   = a;
        it.s1   = b;
        it.eob  = eob;
        // Tap fields are don't-care here; keep them moving anyway
        it.cidx = TAP_W'($urandom);
        it.cval = COEF_BITS'($urandom);
        pending_items.push_back(it);
    endfunction

    function automatic void push_coef(input int idx, input logic signed [COEF_BITS-1:0] v);
        t_fir_item it;
        it.func = FUNC_COEF;
        it.s0   = SAMPLE_BITS'($urandom);
        it.s1   = SAMPLE_BITS'($urandom);
        it.eob  = 1'($urandom_range(0, 1));
        it.cidx = TAP_W'(idx);
        it.cval = v;
        pending_items.push_back(it);
    endfunction

    // Write tap_count through the config channel and wait for its transfer
    task automatic write_taps(input int taps);
        int seen;
        seen = cfg_writes;
        @(negedge clk);
        cfg_ch.tap_count <= TAP_W'(taps);
        cfg_ch.valid     <= 1'b1;
        wait (cfg_writes != seen);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drain: all items sent, all outputs seen, then let the engine go quiet
    task automatic settle();
        while (pending_items.size() != 0 || in_ch.valid || expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random blocks of random length, with tap updates between and inside blocks
    task automatic random_phase(input int taps, input int quota);
        int made;
        int blk_len;
        int tap_idx;
        made = 0;
        write_taps(taps);
        while (made < quota) begin
            if ($urandom_range(0, 5) == 0) begin
                // Index 63 is out of range and must leave the taps untouched
                tap_idx = $urandom_range(0, 63);
                push_coef(tap_idx, rand_coef());
                if (tap_idx < TAP_SLOTS) made++;
            end else begin
                // Occasionally run a block long enough to saturate the fill count
                blk_len = ($urandom_range(0, 15) == 0) ? $urandom_range(64, 72)
                                                       : $urandom_range(1, 12);
                for (int k = 0; k < blk_len; k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        push_coef($urandom_range(0, TAP_SLOTS - 1), rand_coef());
                        made++;
                    end
                    push_sample(rand_sample(), rand_sample(), k == blk_len - 1);
                end
                made += blk_len;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        // Hold every block input at a known value from time zero
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.func         = FUNC_SAMPLE;
        in_ch.sample_ch0   = '0;
        in_ch.sample_ch1   = '0;
        in_ch.end_of_block = 1'b0;
        in_ch.coef_index   = '0;
        in_ch.coef_value   = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.tap_count   = '0;
        out_ch.ready       = 1'b0;

        for (int k = 0; k < TAP_SLOTS; k++) begin
            coef_mem[k] = '0;
            hist0[k]    = '0;
            hist1[k]    = '0;
        end
        fill_count = 0;
        taps_cfg   = int'(TAP_RESET);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Three taps, two at the coefficient extremes; the edge taps saturate
        // when they meet full-scale samples
        write_taps(3);
        push_coef(0, 16'sh8000);
        push_coef(1, 16'sh7FFF);
        push_coef(2, 16'sh4000);
        push_coef(63, 16'sh5555);
        push_coef(62, -16'sd1);
        push_sample(16'sh7FFF, 16'sh8000, 1'b0);
        push_sample(16'sh8000, 16'sh7FFF, 1'b0);
        push_sample(16'sd1, -16'sd1, 1'b0);
        push_sample(16'sd0, 16'sd0, 1'b1);
        // One-sample block: output and flush collapse into a single last output
        push_sample(16'sh8000, 16'sh8000, 1'b1);
        settle();

        // No taps: every output is zero and nothing is flushed
        write_taps(0);
        push_sample(16'sh7FFF, 16'sh8000, 1'b0);
        push_sample(16'sd100, -16'sd100, 1'b1);
        settle();

        // Even tap count: the last tap sits one sample behind the newest
        write_taps(2);
        push_sample(16'sd1000, 16'sd2000, 1'b0);
        push_sample(16'sd30000, -16'sd30000, 1'b0);
        push_sample(-16'sd1, 16'sd1, 1'b0);
        push_sample(16'sd5, 16'sd5, 1'b1);
        settle();

        // Tap count changed in the middle of an open block
        write_taps(1);
        push_sample(16'sd7, -16'sd7, 1'b0);
        push_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 16'sh8000, 1'b0);
        settle();
        write_taps(5);
        push_coef(3, 16'sd12000);
        push_coef(4, -16'sd9000);
        push_sample(16'sd11, 16'sd22, 1'b0);
        push_sample(16'sd33, 16'sd44, 1'b0);
        push_sample(16'sh8000, 16'sh7FFF, 1'b1);
        settle();

        random_phase(63, 16);
        settle();
        hold_armed = 1'b1;
        random_phase(7, 16);
        settle();
        random_phase(4, 16);
        settle();
        random_phase(31, 16);
        settle();
        random_phase(62, 16);
        settle();
        random_phase(9, 16);
        settle();
        random_phase(1, 16);
        settle();

        // Final stretch at full throughput on both sides
        idle_en = 1'b0;
        random_phase(3, 16);
        settle();

        if (fault_count == 0 && expected_outputs.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
